// ----- rtl/wma_pkg.sv -----
// Shared constants and types for the windowed moving average.
// No dependencies; compile first.
package wma_pkg;

  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CFG_BITS        = 7;
  localparam int LEN_RESET       = 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_HOLD
  } wma_state_t;

endpackage

// ----- rtl/wma_div.sv -----
// Sequential signed-by-unsigned divider, one quotient bit per cycle.
// Quotient truncated toward zero. No package dependencies.
module wma_div #(
  parameter int SUM_BITS = 22,
  parameter int LEN_BITS = 7,
  parameter int Q_BITS   = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [SUM_BITS-1:0] dividend,
  input  logic        [LEN_BITS-1:0] divisor,
  output logic                       done,
  output logic signed [Q_BITS-1:0]   quot
);

  localparam int CNT_BITS = $clog2(SUM_BITS + 1);

  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  logic                neg;
  logic [SUM_BITS-1:0] mag;
  logic [LEN_BITS-1:0] rem;
  logic [LEN_BITS:0]   shifted;
  logic [LEN_BITS:0]   diff;
  logic                ge;

  assign shifted = {rem, mag[SUM_BITS-1]};
  assign diff    = shifted - {1'b0, divisor};
  assign ge      = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(SUM_BITS);
      end else if (busy) begin
        if (cnt != '0) begin
          cnt <= cnt - CNT_BITS'(1);
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: load magnitude, shift-subtract, then apply the sign.
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_BITS-1];
      mag <= dividend[SUM_BITS-1] ? SUM_BITS'(-dividend) : SUM_BITS'(dividend);
      rem <= '0;
    end else if (busy) begin
      if (cnt != '0) begin
        rem <= ge ? diff[LEN_BITS-1:0] : shifted[LEN_BITS-1:0];
        mag <= {mag[SUM_BITS-2:0], ge};
      end else begin
        quot <= neg ? Q_BITS'(Q_BITS'(0) - mag[Q_BITS-1:0]) : mag[Q_BITS-1:0];
      end
    end
  end

endmodule

// ----- rtl/windowed_moving_average.sv -----
// Windowed moving average top level: sample ring memory, running sum, divider.
// Depends on wma_pkg and wma_div.
//
//   channel   signals                        direction   payload
//   config    cfg_write_en                   in          window_length
//   input     in_valid / in_stall            in          sample, end_of_stream
//   output    out_valid / out_stall          out         average
//
// A new item is taken only once the last average is in the output register; the
// one-bit-per-cycle divider sets the pace.
// A finished average waits in the output register while the next item is taken.
// Reset (synchronous, rst high), a window_length write and an end_of_stream item
// clear the ring's fill flag, the sum and the position; no clearing pass is needed.
// out_stall holds the output register; in_stall is high while an item is at work.
module windowed_moving_average #(
  parameter int WINDOW_MAX  = wma_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = wma_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [wma_pkg::CFG_BITS-1:0]  window_length,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          end_of_stream,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] average
);

  import wma_pkg::*;

  localparam int ADDR_BITS = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int LEN_BITS  = $clog2(WINDOW_MAX + 1);
  localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW_MAX);
  localparam int LEN_INIT  = (LEN_RESET > WINDOW_MAX) ? WINDOW_MAX : LEN_RESET;

  wma_state_t state, state_next;

  logic [LEN_BITS-1:0]          len;
  logic [LEN_BITS-1:0]          len_wr;
  logic [ADDR_BITS-1:0]         slot;
  logic                         full;
  logic signed [SUM_BITS-1:0]   sum;
  logic signed [SUM_BITS-1:0]   sum_next;
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic                         eos_q;
  logic signed [SAMPLE_BITS-1:0] old_sample;
  logic                         last_slot;

  logic signed [SAMPLE_BITS-1:0] ring [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] ring_q;
  logic                          ring_we;

  logic                          in_take;
  logic                          out_take;
  logic                          out_free;
  logic                          load_out;
  logic                          div_start;
  logic                          div_done;
  logic signed [SAMPLE_BITS-1:0] div_quot;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign out_free = !out_valid || !out_stall;

  // Clamp the written length into 1..WINDOW_MAX.
  always_comb begin
    if (window_length == '0) begin
      len_wr = LEN_BITS'(1);
    end else if (int'(window_length) > WINDOW_MAX) begin
      len_wr = LEN_BITS'(WINDOW_MAX);
    end else begin
      len_wr = LEN_BITS'(window_length);
    end
  end

  // Slots below the position are written since the last clear; the slot at
  // the position holds data only once the ring has wrapped.
  assign old_sample = full ? ring_q : '0;
  assign sum_next   = sum - SUM_BITS'(old_sample) + SUM_BITS'(x_q);
  assign last_slot  = (LEN_BITS'(slot) + LEN_BITS'(1)) == len;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_take) state_next = ST_SUM;
      ST_SUM:  state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) state_next = out_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != ST_IDLE);
    ring_we   = (state == ST_SUM);
    div_start = (state == ST_SUM);
    load_out  = ((state == ST_DIV && div_done) || state == ST_HOLD) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      len       <= LEN_BITS'(LEN_INIT);
      slot      <= '0;
      full      <= 1'b0;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_take) out_valid <= 1'b0;
      if (load_out) out_valid <= 1'b1;
      if (cfg_write_en) begin
        len  <= len_wr;
        slot <= '0;
        full <= 1'b0;
        sum  <= '0;
      end else if (state == ST_SUM) begin
        if (eos_q) begin
          slot <= '0;
          full <= 1'b0;
          sum  <= '0;
        end else begin
          sum  <= sum_next;
          slot <= last_slot ? '0 : slot + ADDR_BITS'(1);
          if (last_slot) full <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      x_q   <= sample;
      eos_q <= end_of_stream;
    end
    if (load_out) average <= div_quot;
  end

  // Ring memory: read at accept, write back the new sample in the next cycle.
  always_ff @(posedge clk) begin
    if (ring_we) ring[slot] <= x_q;
    if (in_take) ring_q <= ring[slot];
  end

  wma_div #(
    .SUM_BITS (SUM_BITS),
    .LEN_BITS (LEN_BITS),
    .Q_BITS   (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .divisor  (len),
    .done     (div_done),
    .quot     (div_quot)
  );

endmodule

// ----- rtl/wma_checker.sv -----
// Port-level checker for windowed_moving_average, bound to the top level.
// Depends on wma_pkg for the default sample width.
module wma_port_checker #(
  parameter int SAMPLE_BITS = wma_pkg::SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] average
);

  logic [1:0] pend;
  logic       in_take;
  logic       out_take;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  // Items taken in but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + {1'b0, in_take} - {1'b0, out_take};
    end
  end

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_take |=> in_stall)
    else $error("input taken again in the cycle after an item");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(average))
    else $error("stalled result changed or dropped");

  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend != 2'd3)
    else $error("more than two items outstanding");

  a_out_has_item: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> pend != 2'd0)
    else $error("result shown without an item taken");

endmodule

bind windowed_moving_average wma_port_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_wma_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .average   (average)
);
